// ===== sv/ddo_pkg.sv =====
// Shared types and constants for the differential drive odometry block.
// Used by ddo_ctrl, ddo_datapath and differential_drive_odometry.
`timescale 1ns / 1ps

package ddo_pkg;

    // Payload and configuration widths
    localparam int COUNT_W    = 16;
    localparam int POS_W      = 48;
    localparam int HEAD_W     = 32;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_PER_PULSE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_WHEEL_BASE = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DISTANCE_PER_PULSE_RESET = 24'd1311;
    localparam logic [CFG_DATA_W-1:0] INVERSE_WHEEL_BASE_RESET = 24'd5461;

    // Shared multiplier: 20 x 32 unsigned, registered product
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Internal arithmetic widths
    localparam int TRAVEL_W = 41;   // count * distance_per_pulse, signed
    localparam int SUM_W    = 42;   // sum or difference of two travels
    localparam int MAG_W    = 40;   // magnitude of difference or of mean travel
    localparam int WIDE_W   = 72;   // recombined split product
    localparam int THMAG_W  = 60;   // heading change magnitude, Q.28
    localparam int T0_W     = 62;   // unwrapped heading sum, signed
    localparam int REM_W    = 61;   // magnitude under reduction
    localparam int DISP_W   = 42;   // displacement magnitude, Q.16
    localparam int CORD_W   = 34;   // CORDIC x and y, Q2.30 with headroom
    localparam int STEP_W   = 5;

    // Angle constants, Q4.28
    localparam logic [30:0]        TWO_PI_Q28     = 31'd1686629713;
    localparam logic [31:0]        PI_Q28_U       = 32'd843314857;
    localparam logic signed [31:0] PI_Q28         = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28    = 32'sd421657428;
    localparam logic signed [31:0] HEADING_LIMIT  = 32'sd843314856;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Modulo reduction runs from 2*pi shifted by this amount down to zero
    localparam logic [STEP_W-1:0] MOD_TOP_SHIFT = 5'd30;

    localparam int DEFAULT_CORDIC_ITERATIONS = 24;
    localparam int ATAN_DEPTH = 30;

    // atan(2^-i) in Q4.28, rounded to nearest
    localparam logic signed [31:0] ATAN_TABLE [ATAN_DEPTH] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32,
        32'sd16,        32'sd8,         32'sd4,        32'sd2,
        32'sd1,         32'sd1
    };

    // Operand selection for the shared multiplier
    typedef enum logic [2:0] {
        MUL_LEFT,
        MUL_RIGHT,
        MUL_TH_LO,
        MUL_TH_HI,
        MUL_SIN_LO,
        MUL_SIN_HI,
        MUL_COS_LO,
        MUL_COS_HI
    } mul_op_t;

    // Controller to datapath commands
    typedef struct packed {
        mul_op_t mul_op;
        logic    load_in;
        logic    load_lt;
        logic    load_rt;
        logic    load_sums;
        logic    load_part;
        logic    load_thmag;
        logic    load_t0;
        logic    mod_init;
        logic    mod_step;
        logic    wrap;
        logic    cordic_init;
        logic    cordic_step;
        logic    load_trig;
        logic    load_r;
        logic    add_x;
        logic    add_y;
        logic    load_out;
    } ddo_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic mod_last;
        logic cordic_last;
    } ddo_stat_t;

endpackage

// ===== sv/ddo_ctrl.sv =====
// Sequencer for the odometry update: one-hot state machine issuing datapath commands.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ddo_stat_t stat,
    output ddo_cmd_t  cmd
);

    typedef enum logic [22:0] {
        S_IDLE   = 23'h000001,
        S_MUL_L  = 23'h000002,
        S_MUL_R  = 23'h000004,
        S_LOAD_R = 23'h000008,
        S_SUMS   = 23'h000010,
        S_TH_LO  = 23'h000020,
        S_TH_HI  = 23'h000040,
        S_TH_MAG = 23'h000080,
        S_TH_SUM = 23'h000100,
        S_ABS    = 23'h000200,
        S_MOD    = 23'h000400,
        S_WRAP   = 23'h000800,
        S_CINIT  = 23'h001000,
        S_CORDIC = 23'h002000,
        S_CFIN   = 23'h004000,
        S_X_LO   = 23'h008000,
        S_X_HI   = 23'h010000,
        S_X_SUM  = 23'h020000,
        S_X_ACC  = 23'h040000,
        S_Y_HI   = 23'h080000,
        S_Y_SUM  = 23'h100000,
        S_Y_ACC  = 23'h200000,
        S_DONE   = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_LEFT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                cmd.mul_op = MUL_LEFT;
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                cmd.load_lt = 1'b1;
                cmd.mul_op  = MUL_RIGHT;
                state_next  = S_LOAD_R;
            end
            S_LOAD_R:
            begin
                cmd.load_rt = 1'b1;
                state_next  = S_SUMS;
            end
            S_SUMS:
            begin
                cmd.load_sums = 1'b1;
                state_next    = S_TH_LO;
            end
            S_TH_LO:
            begin
                cmd.mul_op = MUL_TH_LO;
                state_next = S_TH_HI;
            end
            S_TH_HI:
            begin
                cmd.load_part = 1'b1;
                cmd.mul_op    = MUL_TH_HI;
                state_next    = S_TH_MAG;
            end
            S_TH_MAG:
            begin
                cmd.load_thmag = 1'b1;
                state_next     = S_TH_SUM;
            end
            S_TH_SUM:
            begin
                cmd.load_t0 = 1'b1;
                state_next  = S_ABS;
            end
            S_ABS:
            begin
                cmd.mod_init = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (stat.cordic_last)
                begin
                    state_next = S_CFIN;
                end
            end
            S_CFIN:
            begin
                cmd.load_trig = 1'b1;
                state_next    = S_X_LO;
            end
            S_X_LO:
            begin
                cmd.mul_op = MUL_SIN_LO;
                state_next = S_X_HI;
            end
            S_X_HI:
            begin
                cmd.load_part = 1'b1;
                cmd.mul_op    = MUL_SIN_HI;
                state_next    = S_X_SUM;
            end
            S_X_SUM:
            begin
                cmd.load_r = 1'b1;
                state_next = S_X_ACC;
            end
            S_X_ACC:
            begin
                cmd.add_x  = 1'b1;
                cmd.mul_op = MUL_COS_LO;
                state_next = S_Y_HI;
            end
            S_Y_HI:
            begin
                cmd.load_part = 1'b1;
                cmd.mul_op    = MUL_COS_HI;
                state_next    = S_Y_SUM;
            end
            S_Y_SUM:
            begin
                cmd.load_r = 1'b1;
                state_next = S_Y_ACC;
            end
            S_Y_ACC:
            begin
                cmd.add_y  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/ddo_datapath.sv =====
// Odometry datapath: config registers, shared multiplier, heading reduction,
// iterative CORDIC and pose accumulators. Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = DEFAULT_CORDIC_ITERATIONS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [COUNT_W-1:0]     left_count,
    input  logic signed [COUNT_W-1:0]     right_count,
    input  ddo_cmd_t                      cmd,
    output ddo_stat_t                     stat,
    output logic signed [POS_W-1:0]       x_position,
    output logic signed [POS_W-1:0]       y_position,
    output logic signed [HEAD_W-1:0]      heading
);

    // Configuration
    logic [CFG_DATA_W-1:0] dpp_reg, iwb_reg;

    // Pose state
    logic [HEAD_W-1:0] heading_acc_reg;
    logic [POS_W-1:0]  x_acc_reg, y_acc_reg;

    // Per-word working registers
    logic signed [COUNT_W-1:0]  lc_reg, rc_reg;
    logic [PROD_W-1:0]          prod_reg, part_reg;
    logic signed [TRAVEL_W-1:0] lt_reg, rt_reg;
    logic [MAG_W-1:0]           diff_mag_reg, disp_mag_reg;
    logic                       diff_neg_reg, disp_neg_reg;
    logic [THMAG_W-1:0]         thmag_reg;
    logic signed [T0_W-1:0]     t0_reg;
    logic [REM_W-1:0]           rem_reg;
    logic                       t0_neg_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [CORD_W-1:0]   cx_reg, cy_reg;
    logic signed [31:0]         cz_reg;
    logic                       flip_reg;
    logic [MUL_B_W-1:0]         gs_reg, gc_reg;
    logic                       x_neg_reg, y_neg_reg;
    logic [DISP_W-1:0]          r_reg;

    // Combinational helpers
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [COUNT_W-1:0]         lc_mag, rc_mag;
    logic signed [TRAVEL_W-1:0] prod_travel;
    logic signed [SUM_W-1:0]    diff_w, sum_w, diff_abs, sum_abs;
    logic [WIDE_W-1:0]          wide_w;
    logic signed [T0_W-1:0]     hd_ext, th_ext;
    logic [REM_W-1:0]           mod_sub;
    logic [30:0]                rem_low;
    logic [31:0]                wrap_pos, wrap_out;
    logic signed [31:0]         head_s;
    logic signed [CORD_W-1:0]   cdx, cdy, cx_abs, cy_abs;
    logic signed [31:0]         atan_step;
    logic [POS_W-1:0]           r_ext;

    assign stat.mod_last    = (step_reg == '0);
    assign stat.cordic_last = (step_reg == STEP_W'(CORDIC_ITERATIONS - 1));

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpp_reg <= DISTANCE_PER_PULSE_RESET;
            iwb_reg <= INVERSE_WHEEL_BASE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISTANCE_PER_PULSE: dpp_reg <= cfg_data;
                REG_INVERSE_WHEEL_BASE: iwb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared multiplier operand select
    assign lc_mag = lc_reg[COUNT_W-1] ? COUNT_W'(-lc_reg) : COUNT_W'(lc_reg);
    assign rc_mag = rc_reg[COUNT_W-1] ? COUNT_W'(-rc_reg) : COUNT_W'(rc_reg);

    always_comb
    begin
        case (cmd.mul_op)
            MUL_LEFT:
            begin
                mul_a = MUL_A_W'(lc_mag);
                mul_b = MUL_B_W'(dpp_reg);
            end
            MUL_RIGHT:
            begin
                mul_a = MUL_A_W'(rc_mag);
                mul_b = MUL_B_W'(dpp_reg);
            end
            MUL_TH_LO:
            begin
                mul_a = diff_mag_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(iwb_reg);
            end
            MUL_TH_HI:
            begin
                mul_a = diff_mag_reg[MAG_W-1:MUL_A_W];
                mul_b = MUL_B_W'(iwb_reg);
            end
            MUL_SIN_LO:
            begin
                mul_a = disp_mag_reg[MUL_A_W-1:0];
                mul_b = gs_reg;
            end
            MUL_SIN_HI:
            begin
                mul_a = disp_mag_reg[MAG_W-1:MUL_A_W];
                mul_b = gs_reg;
            end
            MUL_COS_LO:
            begin
                mul_a = disp_mag_reg[MUL_A_W-1:0];
                mul_b = gc_reg;
            end
            MUL_COS_HI:
            begin
                mul_a = disp_mag_reg[MAG_W-1:MUL_A_W];
                mul_b = gc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Travel magnitude fits 39 bits
    assign prod_travel = $signed({2'b00, prod_reg[TRAVEL_W-3:0]});

    // Travel difference and sum
    assign diff_w   = {lt_reg[TRAVEL_W-1], lt_reg} - {rt_reg[TRAVEL_W-1], rt_reg};
    assign sum_w    = {lt_reg[TRAVEL_W-1], lt_reg} + {rt_reg[TRAVEL_W-1], rt_reg};
    assign diff_abs = diff_w[SUM_W-1] ? -diff_w : diff_w;
    assign sum_abs  = sum_w[SUM_W-1] ? -sum_w : sum_w;

    // Recombine hi/lo partial products: hi * 2^20 + lo
    assign wide_w = {prod_reg, {MUL_A_W{1'b0}}} + WIDE_W'(part_reg);

    // Heading sum operands
    assign hd_ext = T0_W'($signed(heading_acc_reg));
    assign th_ext = $signed({2'b00, thmag_reg});

    // Reduction step: 2*pi shifted left by the step count
    assign mod_sub = REM_W'(TWO_PI_Q28) << step_reg;

    // Fold the remainder back into plus or minus pi
    assign rem_low  = rem_reg[30:0];
    assign wrap_pos = (t0_neg_reg && (rem_low != '0)) ?
                      32'(TWO_PI_Q28) - 32'(rem_low) : 32'(rem_low);
    assign wrap_out = (wrap_pos >= PI_Q28_U) ? wrap_pos - 32'(TWO_PI_Q28) : wrap_pos;

    assign head_s = $signed(heading_acc_reg);

    // CORDIC step terms, shifts round toward minus infinity
    assign cdx       = cy_reg >>> step_reg;
    assign cdy       = cx_reg >>> step_reg;
    assign atan_step = ATAN_TABLE[step_reg];
    assign cx_abs    = cx_reg[CORD_W-1] ? -cx_reg : cx_reg;
    assign cy_abs    = cy_reg[CORD_W-1] ? -cy_reg : cy_reg;

    assign r_ext = POS_W'(r_reg);

    // Control-side state: pose, reduction/iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_acc_reg <= '0;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            step_reg        <= '0;
        end
        else
        begin
            if (cmd.wrap)
            begin
                heading_acc_reg <= wrap_out;
            end
            if (cmd.add_x)
            begin
                x_acc_reg <= x_neg_reg ? x_acc_reg - r_ext : x_acc_reg + r_ext;
            end
            if (cmd.add_y)
            begin
                y_acc_reg <= y_neg_reg ? y_acc_reg - r_ext : y_acc_reg + r_ext;
            end
            if (cmd.mod_init)
            begin
                step_reg <= MOD_TOP_SHIFT;
            end
            else if (cmd.mod_step)
            begin
                step_reg <= step_reg - 1'b1;
            end
            else if (cmd.cordic_init)
            begin
                step_reg <= '0;
            end
            else if (cmd.cordic_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Working registers, no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.load_in)
        begin
            lc_reg <= left_count;
            rc_reg <= right_count;
        end
        if (cmd.load_lt)
        begin
            lt_reg <= lc_reg[COUNT_W-1] ? -prod_travel : prod_travel;
        end
        if (cmd.load_rt)
        begin
            rt_reg <= rc_reg[COUNT_W-1] ? -prod_travel : prod_travel;
        end
        if (cmd.load_sums)
        begin
            diff_mag_reg <= diff_abs[MAG_W-1:0];
            diff_neg_reg <= diff_w[SUM_W-1];
            // mean travel, truncated toward zero
            disp_mag_reg <= sum_abs[MAG_W:1];
            disp_neg_reg <= sum_w[SUM_W-1];
        end
        if (cmd.load_part)
        begin
            part_reg <= prod_reg;
        end
        if (cmd.load_thmag)
        begin
            thmag_reg <= wide_w[THMAG_W+3:4];
        end
        if (cmd.load_t0)
        begin
            t0_reg <= diff_neg_reg ? hd_ext - th_ext : hd_ext + th_ext;
        end
        if (cmd.mod_init)
        begin
            rem_reg    <= t0_reg[T0_W-1] ? REM_W'(-t0_reg) : REM_W'(t0_reg);
            t0_neg_reg <= t0_reg[T0_W-1];
        end
        else if (cmd.mod_step)
        begin
            if (rem_reg >= mod_sub)
            begin
                rem_reg <= rem_reg - mod_sub;
            end
        end
        if (cmd.cordic_init)
        begin
            cx_reg <= CORDIC_GAIN_Q30;
            cy_reg <= '0;
            // beyond plus or minus pi/2: rotate by pi and negate the results
            if (head_s > HALF_PI_Q28)
            begin
                cz_reg   <= head_s - PI_Q28;
                flip_reg <= 1'b1;
            end
            else if (head_s < -HALF_PI_Q28)
            begin
                cz_reg   <= head_s + PI_Q28;
                flip_reg <= 1'b1;
            end
            else
            begin
                cz_reg   <= head_s;
                flip_reg <= 1'b0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (!cz_reg[31])
            begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - atan_step;
            end
            else
            begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + atan_step;
            end
        end
        if (cmd.load_trig)
        begin
            gs_reg    <= cy_abs[MUL_B_W-1:0];
            gc_reg    <= cx_abs[MUL_B_W-1:0];
            x_neg_reg <= disp_neg_reg ^ cy_reg[CORD_W-1] ^ flip_reg;
            y_neg_reg <= disp_neg_reg ^ cx_reg[CORD_W-1] ^ flip_reg;
        end
        if (cmd.load_r)
        begin
            r_reg <= wide_w[WIDE_W-1:30];
        end
        if (cmd.load_out)
        begin
            x_position <= $signed(x_acc_reg);
            y_position <= $signed(y_acc_reg);
            heading    <= $signed(heading_acc_reg);
        end
    end

endmodule

// ===== sv/differential_drive_odometry.sv =====
// Top level of the differential drive odometry block.
// Instantiates ddo_ctrl and ddo_datapath; depends on ddo_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready, left_count, right_count): one word per
//   sample period with the signed encoder pulse counts of both wheels.
//   Output channel (out_valid/out_ready, x_position, y_position, heading):
//   one word per input word with the pose after the update.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   distance_per_pulse, index 1 is inverse_wheel_base; other indexes are
//   ignored. cfg_ready is always high; write only while the block is idle.
//   Sequencing: a new input word is taken only once the previous result has
//   been loaded into the output register. The time per word is set by the
//   31-step reduction of the heading modulo 2*pi, the CORDIC iterations and
//   the single shared 20x32 multiplier, all sequenced one step per cycle.
//   Stalls: the result sits in an output register; the next input word is
//   taken and worked on while it waits, and only the final load stalls.
//   Reset: pose clears to zero and both config registers return to their
//   defaults; nothing is pending.
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = DEFAULT_CORDIC_ITERATIONS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COUNT_W-1:0] left_count,
    input  logic signed [COUNT_W-1:0] right_count,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [POS_W-1:0]   x_position,
    output logic signed [POS_W-1:0]   y_position,
    output logic signed [HEAD_W-1:0]  heading,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    ddo_cmd_t  cmd;
    ddo_stat_t stat;

    assign cfg_ready = 1'b1;

    ddo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ddo_datapath
    #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_count  (left_count),
        .right_count (right_count),
        .cmd         (cmd),
        .stat        (stat),
        .x_position  (x_position),
        .y_position  (y_position),
        .heading     (heading)
    );

    // Once a word is taken the block is busy for the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("input taken while a word is in progress");

    // Delivered heading always lies within plus or minus pi
    a_heading_wrapped: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading <= HEADING_LIMIT) && (heading >= -HEADING_LIMIT)
    ) else $error("heading outside the wrapped range");

    // Reduction and CORDIC counters never run together
    a_single_loop: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.mod_step |-> !cmd.cordic_step && !cmd.cordic_init
    ) else $error("heading reduction overlaps CORDIC");

endmodule
